// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the epoch detector checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, switched off while reset is held
`define SED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("epoch detector check failed");

// next-cycle implication that also runs through reset
`define SED_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("epoch detector check failed");

`endif

// ===== rtl/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// widths, constants, coefficient table and shared types of the epoch detector
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

    // field and datapath widths
    localparam int SMP_W      = 16;
    localparam int VAL_W      = 48;
    localparam int COEF_W     = 32;
    localparam int GAP_W      = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int HP_SHIFT   = 12;
    localparam int HP_W       = SMP_W + 1 + HP_SHIFT;
    localparam int FRAC_SHIFT = 28;
    localparam int SPLIT      = 24;
    localparam int PHI_W      = VAL_W - SPLIT + COEF_W;
    localparam int PLO_W      = SPLIT + 1 + COEF_W;
    localparam int FULL_W     = VAL_W + COEF_W + 1;
    localparam int PROD_W     = 52;
    localparam int ACC_W      = 54;
    localparam int RES_STEPS  = 4;

    localparam int HALF_WINDOW_DEF = 109;
    localparam int OUT_DEPTH       = 4;

    localparam logic [GAP_W-1:0] GAP_MAX        = '1;
    localparam logic [GAP_W-1:0] MIN_PERIOD_RST = GAP_W'(44);
    localparam logic [GAP_W-1:0] MAX_PERIOD_RST = GAP_W'(275);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Q3.28 resonator taps: 4r, -6r^2, 4r^3, -r^4 with r = 0.98
    localparam logic signed [COEF_W-1:0] COEF [RES_STEPS] = '{
        32'sd1052266988, -32'sd1546832472, 32'sd1010597215, -32'sd247596318
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD = 2'd0,
        CFG_MAX_PERIOD = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_MID,
        RS_OLD
    } t_ring_state;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] acc;
        logic signed [SMP_W-1:0] smp;
    } t_res_out;

    typedef struct packed {
        logic signed [SMP_W-1:0] delayed;
        logic                    epoch;
        logic [GAP_W-1:0]        gap;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sed_resonator.sv =====
// ----------------------------------------------------------------------------
// sed_resonator
// high-pass and fourth-order resonator, one shared split multiplier pass per tap
// ----------------------------------------------------------------------------
`default_nettype none

module sed_resonator
    import sed_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SMP_W-1:0] i_sample,
    output logic                         o_free,
    output t_res_out                     o_res
);

    localparam logic [1:0] STEP_LAST = 2'(RES_STEPS - 1);

    // issue side
    logic                    r_busy;
    logic [1:0]              r_step;
    logic [1:0]              r_iptr;
    logic [1:0]              r_wptr;
    logic signed [SMP_W-1:0] r_last;
    logic signed [SMP_W-1:0] r_smp;
    logic signed [HP_W-1:0]  r_hp;
    logic signed [VAL_W-1:0] r_hist [RES_STEPS];

    // multiply stage
    logic                    r_m_valid;
    logic [1:0]              r_m_step;
    logic [1:0]              r_m_wptr;
    logic signed [SMP_W-1:0] r_m_smp;
    logic signed [PHI_W-1:0] r_m_phi;
    logic signed [PLO_W-1:0] r_m_plo;

    // combine stage
    logic                     r_c_valid;
    logic [1:0]               r_c_step;
    logic [1:0]               r_c_wptr;
    logic signed [SMP_W-1:0]  r_c_smp;
    logic signed [PROD_W-1:0] r_c_prod;

    // accumulate and result
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_f_valid;
    logic signed [VAL_W-1:0] r_f_acc;
    logic signed [SMP_W-1:0] r_f_smp;

    logic [1:0]                 w_k;
    logic [1:0]                 w_hidx;
    logic signed [VAL_W-1:0]    w_h;
    logic signed [VAL_W-SPLIT-1:0] w_hi;
    logic signed [SPLIT:0]      w_lo;
    logic signed [PHI_W-1:0]    w_phi;
    logic signed [PLO_W-1:0]    w_plo;
    logic signed [FULL_W-1:0]   w_full;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_base;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [VAL_W-1:0]    w_sat;
    logic signed [HP_W-1:0]     w_hp;

    // taps run 1, 2, 3 then 0 so the newest history entry is needed last
    assign w_k    = r_step + 2'd1;
    assign w_hidx = r_wptr - w_k - 2'd1;
    assign w_h    = r_hist[w_hidx];
    assign w_hi   = w_h[VAL_W-1:SPLIT];
    assign w_lo   = {1'b0, w_h[SPLIT-1:0]};
    assign w_phi  = w_hi * COEF[w_k];
    assign w_plo  = w_lo * COEF[w_k];

    // floor of the full product over 2^28
    assign w_full = (FULL_W'(r_m_phi) <<< SPLIT) + FULL_W'(r_m_plo);
    assign w_prod = PROD_W'(w_full >>> FRAC_SHIFT);

    assign w_base = (r_c_step == 2'd0) ? ACC_W'(r_hp) : r_acc;
    assign w_sum  = w_base + ACC_W'(r_c_prod);

    always_comb begin
        if (w_sum > ACC_W'(VAL_MAX)) begin
            w_sat = VAL_MAX;
        end else if (w_sum < ACC_W'(VAL_MIN)) begin
            w_sat = VAL_MIN;
        end else begin
            w_sat = w_sum[VAL_W-1:0];
        end
    end

    assign w_hp = (HP_W'(i_sample) - HP_W'(r_last)) <<< HP_SHIFT;

    assign o_free = !r_busy || (r_step == STEP_LAST);
    assign o_res  = '{valid: r_f_valid, acc: r_f_acc, smp: r_f_smp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= 2'd0;
            r_iptr    <= 2'd0;
            r_last    <= '0;
            r_m_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_f_valid <= 1'b0;
            for (int i = 0; i < RES_STEPS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_iptr <= r_iptr + 2'd1;
                r_last <= i_sample;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
            r_m_valid <= r_busy;
            r_c_valid <= r_m_valid;
            r_f_valid <= r_c_valid && (r_c_step == STEP_LAST);
            if (r_c_valid && (r_c_step == STEP_LAST)) begin
                r_hist[r_c_wptr] <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_smp  <= i_sample;
            r_hp   <= w_hp;
            r_wptr <= r_iptr;
        end
        r_m_step <= r_step;
        r_m_wptr <= r_wptr;
        r_m_smp  <= r_smp;
        r_m_phi  <= w_phi;
        r_m_plo  <= w_plo;
        r_c_step <= r_m_step;
        r_c_wptr <= r_m_wptr;
        r_c_smp  <= r_m_smp;
        r_c_prod <= w_prod;
        if (r_c_valid) begin
            r_acc <= w_sum;
        end
        r_f_acc <= w_sat;
        r_f_smp <= r_c_smp;
    end

endmodule

`default_nettype wire

// ===== rtl/speech_epoch_detector_unit.sv =====
// ----------------------------------------------------------------------------
// speech_epoch_detector_unit
// zero-frequency resonator epoch marker with mean-ring detrending and delay line
// ----------------------------------------------------------------------------
// acceptance: a new request is taken only once the previous one has issued all four
//   of its taps to the resonator's one shared split multiplier
// reset: synchronous active low; clears pointers, fill counts, resonator
//   history, window sum and epoch state; ring entries read as zero until written
`default_nettype none

module speech_epoch_detector_unit
    import sed_pkg::*;
#(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [SMP_W-1:0] i_sample,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [SMP_W-1:0]      o_delayed_sample,
    output logic                         o_epoch,
    output logic [GAP_W-1:0]             o_gap
);

    // window of 2N+1 resonator outputs, centre entry N items old
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int MP_W    = $clog2(WIN_LEN);
    localparam int MF_W    = $clog2(WIN_LEN + 1);
    localparam int DP_W    = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
    localparam int DF_W    = $clog2(HALF_WINDOW + 1);
    localparam int SUM_W   = VAL_W + $clog2(WIN_LEN);
    localparam int DIFF_W  = SUM_W + 2;
    localparam int FP_W    = $clog2(OUT_DEPTH);
    localparam int OC_W    = $clog2(OUT_DEPTH + 1);

    // configuration
    logic [GAP_W-1:0] r_min_period;
    logic [GAP_W-1:0] r_max_period;

    // resonator front end
    t_res_out w_res;
    logic     w_res_free;
    logic     w_take;

    // ring sequencer
    t_ring_state r_state;
    t_ring_state n_state;
    logic [MP_W-1:0]         w_mrd_addr;
    logic                    w_ring_wr;
    logic signed [VAL_W-1:0] r_acc_q;
    logic signed [SMP_W-1:0] r_smp_q;

    // mean ring and delay line storage
    logic signed [VAL_W-1:0] r_mean_mem  [WIN_LEN];
    logic signed [SMP_W-1:0] r_delay_mem [HALF_WINDOW];
    logic signed [VAL_W-1:0] r_mrd;
    logic signed [SMP_W-1:0] r_drd;

    logic [MP_W-1:0]          r_mp;
    logic [MP_W-1:0]          r_mid;
    logic [MF_W-1:0]          r_mfill;
    logic [DP_W-1:0]          r_dp;
    logic [DF_W-1:0]          r_dfill;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic                     r_was_neg;
    logic [GAP_W-1:0]         r_gap_count;

    logic signed [VAL_W-1:0]  w_midval;
    logic signed [VAL_W-1:0]  w_oldval;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SMP_W-1:0]  w_delayed;
    logic                     w_epoch;
    t_result                  w_result;

    // result queue and request accounting
    t_result          r_fifo [OUT_DEPTH];
    logic [FP_W-1:0]  r_wp;
    logic [FP_W-1:0]  r_rp;
    logic [OC_W-1:0]  r_fcnt;
    logic [OC_W-1:0]  r_cnt;
    logic             w_pop;
    t_result          w_head;

    // ---------------------------------------------------------------------
    // configuration writes, unknown indexes are dropped
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST;
            r_max_period <= MAX_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_PERIOD: r_min_period <= i_cfg_data;
                CFG_MAX_PERIOD: r_max_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // input side: a request enters the resonator as soon as its multiplier
    // frees up and the result queue can hold everything in flight
    // ---------------------------------------------------------------------
    assign o_in_ready = i_rst_n && w_res_free && (r_cnt != OC_W'(OUT_DEPTH));
    assign w_take     = i_in_valid && o_in_ready;

    sed_resonator u_resonator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_take),
        .i_sample (i_sample),
        .o_free   (w_res_free),
        .o_res    (w_res)
    );

    // ---------------------------------------------------------------------
    // ring sequencer: centre entry read, oldest entry read, then write back
    // results arrive no faster than the resonator issues its four taps, so the three-step pass
    // always finishes its write before the next pass reads
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_mrd_addr = r_mid;
        w_ring_wr  = 1'b0;
        case (r_state)
            RS_IDLE: begin
                w_mrd_addr = r_mid;
                if (w_res.valid) begin
                    n_state = RS_MID;
                end
            end
            RS_MID: begin
                w_mrd_addr = r_mp;
                n_state    = RS_OLD;
            end
            RS_OLD: begin
                w_ring_wr = 1'b1;
                n_state   = RS_IDLE;
            end
            default: begin
                n_state = RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == RS_IDLE) && w_res.valid) begin
            r_acc_q <= w_res.acc;
            r_smp_q <= w_res.smp;
        end
    end

    // memories with registered read data
    always_ff @(posedge i_clk) begin
        if (w_ring_wr) begin
            r_mean_mem[r_mp] <= r_acc_q;
        end
        r_mrd <= r_mean_mem[w_mrd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_wr) begin
            r_delay_mem[r_dp] <= r_smp_q;
        end
        r_drd <= r_delay_mem[r_dp];
    end

    // entries at or above the fill count have never been written: zero
    assign w_midval  = (MF_W'(r_mid) < r_mfill) ? r_mrd : '0;
    assign w_oldval  = (MF_W'(r_mp) < r_mfill) ? r_mrd : '0;
    assign w_delayed = (DF_W'(r_dp) < r_dfill) ? r_drd : '0;

    // sign of L * centre - window sum stands in for centre minus mean
    assign w_diff = DIFF_W'(w_midval) * DIFF_W'(WIN_LEN) - DIFF_W'(r_sum);

    // rising crossing after the minimum gap, or forced at the maximum
    assign w_epoch = (r_was_neg && !r_neg && (r_gap_count >= r_min_period))
                     || (r_gap_count >= r_max_period);

    assign w_result = '{delayed: w_delayed, epoch: w_epoch, gap: r_gap_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp        <= '0;
            r_mid       <= MP_W'(HALF_WINDOW + 1);
            r_mfill     <= '0;
            r_dp        <= '0;
            r_dfill     <= '0;
            r_sum       <= '0;
            r_neg       <= 1'b0;
            r_was_neg   <= 1'b0;
            r_gap_count <= '0;
        end else begin
            if (r_state == RS_MID) begin
                r_neg <= w_diff[DIFF_W-1];
            end
            if (w_ring_wr) begin
                r_sum <= r_sum + SUM_W'(r_acc_q) - SUM_W'(w_oldval);
                r_mp  <= (r_mp == MP_W'(WIN_LEN - 1)) ? '0 : r_mp + 1'b1;
                r_mid <= (r_mid == MP_W'(WIN_LEN - 1)) ? '0 : r_mid + 1'b1;
                if (r_mfill != MF_W'(WIN_LEN)) begin
                    r_mfill <= r_mfill + 1'b1;
                end
                r_dp <= (r_dp == DP_W'(HALF_WINDOW - 1)) ? '0 : r_dp + 1'b1;
                if (r_dfill != DF_W'(HALF_WINDOW)) begin
                    r_dfill <= r_dfill + 1'b1;
                end
                r_was_neg <= r_neg;
                if (w_epoch) begin
                    r_gap_count <= GAP_W'(1);
                end else if (r_gap_count != GAP_MAX) begin
                    r_gap_count <= r_gap_count + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // result queue: sized for every request that can be in flight, so the
    // fixed-timing pipeline never has to stall
    // ---------------------------------------------------------------------
    assign w_pop  = o_out_valid && i_out_ready;
    assign w_head = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_ring_wr) begin
            r_fifo[r_wp] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_ring_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fcnt <= r_fcnt + OC_W'(w_ring_wr) - OC_W'(w_pop);
            r_cnt  <= r_cnt + OC_W'(w_take) - OC_W'(w_pop);
        end
    end

    assign o_out_valid      = i_rst_n && (r_fcnt != '0);
    assign o_delayed_sample = w_head.delayed;
    assign o_epoch          = w_head.epoch;
    assign o_gap            = w_head.gap;

endmodule

`default_nettype wire

// ===== rtl/sed_checker.sv =====
// ----------------------------------------------------------------------------
// sed_checker
// port-level checks of the epoch detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sed_checker
    import sed_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [SMP_W-1:0] o_delayed_sample,
    input wire logic                    o_epoch,
    input wire logic [GAP_W-1:0]        o_gap
);

    // result payload as one word
    logic [SMP_W+GAP_W:0] w_payload;

    assign w_payload = {o_delayed_sample, o_epoch, o_gap};

    // queue empties on reset
    `SED_ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // a taken request occupies the resonator for the following cycle
    `SED_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled result stays offered
    `SED_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // and keeps its payload
    `SED_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(w_payload))

endmodule

bind speech_epoch_detector_unit sed_checker u_sed_checker (.*);

`default_nettype wire
